@@ sv/drc_pkg.sv @@
// ----------------------------------------------------------------------------
// drc_pkg: shared types and constants for the dirty range coalescer
// Action codes, input and result transaction payloads, and the table entry.
// ----------------------------------------------------------------------------
package drc_pkg;

  // Default number of table entries
  localparam int unsigned TableEntriesDef = 4;

  // Action codes carried by an input transaction
  typedef enum logic [1:0] {
    ACT_MARK   = 2'd0,
    ACT_FORGET = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // Input transaction payload
  typedef struct packed {
    action_e     action;
    logic [31:0] resource;
    logic [31:0] offset;
    logic [31:0] length;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [31:0] upload_resource;
    logic [31:0] upload_start;
    logic [31:0] upload_length;
    logic        last;
  } out_item_t;

  // One table entry: resource and its dirty byte range [start, stop)
  typedef struct packed {
    logic [31:0] resource;
    logic [31:0] start;
    logic [31:0] stop;
  } entry_t;

endpackage

@@ sv/drc_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// drc_cmp_unit: shared compare and merge unit
// Matches one table entry against the pending item, widens its range and
// forms the upload length of the entry.
// ----------------------------------------------------------------------------
module drc_cmp_unit
  import drc_pkg::*;
(
  input  entry_t      entry_i,
  input  logic [31:0] resource_i,
  input  logic [31:0] offset_i,
  input  logic [31:0] stop_i,
  output logic        hit_o,
  output entry_t      merged_o,
  output logic [31:0] upload_length_o
);

  // Match on resource
  assign hit_o = (entry_i.resource == resource_i);

  // Widen: lower start, higher end (unsigned compare)
  always_comb begin
    merged_o.resource = entry_i.resource;
    merged_o.start    = (offset_i < entry_i.start) ? offset_i : entry_i.start;
    merged_o.stop     = (stop_i > entry_i.stop) ? stop_i : entry_i.stop;
  end

  // Length wraps modulo 2^32
  assign upload_length_o = entry_i.stop - entry_i.start;

endmodule

@@ sv/dirty_range_coalescer.sv @@
// ----------------------------------------------------------------------------
// dirty_range_coalescer: small table that merges dirty byte ranges
// Marks widen or append per-resource entries, forgets drop a resource, and
// flushes (or a mark that misses on a full table) emit all entries as uploads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one action per
//   transaction: mark, forget, flush; the unused code is dropped.
//   Output channel (out_valid_o / out_stall_i / out_data_o) gives one upload
//   per transaction; last flags the final upload of a flush or spill.
//   A single compare/merge unit scans the table one entry at a time, each
//   by a registered table read, then evaluate. A mark on an empty table is
//   written from idle without a scan; otherwise a mark scans until a hit and
//   a forget scans all entries, each removed entry adding a read of the last
//   entry and a move into the freed slot. A flush emits one upload per entry;
//   a spill emits all entries after the full scan of the mark, then stores it.
//   The input stalls while a transaction is being processed.
//   A stalled output holds its upload; the scan waits until the output
//   register is free. The output register lets the next input transaction
//   be taken while an upload still waits.
//   Reset empties the table at once (entry count cleared); no clearing pass.
// ----------------------------------------------------------------------------
module dirty_range_coalescer
  import drc_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TableEntries);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  // Sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_READ      = 3'd1;
  localparam logic [2:0] S_EVAL      = 3'd2;
  localparam logic [2:0] S_READ_LAST = 3'd3;
  localparam logic [2:0] S_MOVE      = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            spill_q, spill_d;
  action_e         op_q;
  logic [31:0]     res_q, off_q, stop_q;
  logic            out_valid_q;
  out_item_t       out_q;

  entry_t          mem_q [TableEntries];
  entry_t          rd_q;
  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  entry_t          wr_data;

  logic            hit;
  entry_t          merged;
  logic [31:0]     up_len;
  logic [31:0]     in_stop;
  logic [CntW-1:0] idx_ext;
  logic            at_last;
  logic            emitting;
  logic            out_free;
  logic            out_load;
  entry_t          new_entry;

  // Shared compare and merge unit
  drc_cmp_unit u_cmp (
    .entry_i        (rd_q),
    .resource_i     (res_q),
    .offset_i       (off_q),
    .stop_i         (stop_q),
    .hit_o          (hit),
    .merged_o       (merged),
    .upload_length_o(up_len)
  );

  assign in_stop   = in_data_i.offset + in_data_i.length;
  assign idx_ext   = CntW'(idx_q);
  assign at_last   = ((idx_ext + CntOne) == cnt_q);
  assign emitting  = spill_q || (op_q == ACT_FLUSH);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign new_entry = '{resource: res_q, start: off_q, stop: stop_q};

  // Sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    spill_d  = spill_q;
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_data  = merged;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d   = '0;
          spill_d = 1'b0;
          case (in_data_i.action)
            ACT_MARK: begin
              if (cnt_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{resource: in_data_i.resource, start: in_data_i.offset,
                            stop: in_stop};
                cnt_d   = CntOne;
              end else begin
                state_d = S_READ;
              end
            end
            ACT_FORGET, ACT_FLUSH: begin
              if (cnt_q != '0) state_d = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (emitting) begin
          // Emit one upload when the output register is free
          if (out_free) begin
            out_load = 1'b1;
            if (at_last) begin
              state_d = S_IDLE;
              spill_d = 1'b0;
              if (spill_q) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = new_entry;
                cnt_d   = CntOne;
              end else begin
                cnt_d = '0;
              end
            end else begin
              idx_d   = idx_q + IdxW'(1);
              state_d = S_READ;
            end
          end
        end else begin
          case (op_q)
            ACT_MARK: begin
              if (hit) begin
                wr_en   = 1'b1;
                state_d = S_IDLE;
              end else if (!at_last) begin
                idx_d   = idx_q + IdxW'(1);
                state_d = S_READ;
              end else if (cnt_q == CntFull) begin
                spill_d = 1'b1;
                idx_d   = '0;
                state_d = S_READ;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cnt_q[IdxW-1:0];
                wr_data = new_entry;
                cnt_d   = cnt_q + CntOne;
                state_d = S_IDLE;
              end
            end
            ACT_FORGET: begin
              if (hit) begin
                state_d = S_READ_LAST;
              end else if (!at_last) begin
                idx_d   = idx_q + IdxW'(1);
                state_d = S_READ;
              end else begin
                state_d = S_IDLE;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_READ_LAST: begin
        rd_en   = 1'b1;
        rd_addr = IdxW'(cnt_q - CntOne);
        state_d = S_MOVE;
      end
      S_MOVE: begin
        // Move the last entry into the freed slot and recheck that slot
        wr_en   = 1'b1;
        wr_data = rd_q;
        cnt_d   = cnt_q - CntOne;
        if (idx_ext < (cnt_q - CntOne)) begin
          state_d = S_READ;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      spill_q     <= 1'b0;
      op_q        <= ACT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      spill_q <= spill_d;
      if (state_q == S_IDLE && in_valid_i) op_q <= in_data_i.action;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      res_q  <= in_data_i.resource;
      off_q  <= in_data_i.offset;
      stop_q <= in_stop;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.upload_resource <= rd_q.resource;
      out_q.upload_start    <= rd_q.start;
      out_q.upload_length   <= up_len;
      out_q.last            <= at_last;
    end
  end

  // Entry table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Entry count never exceeds the table size
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("entry count above table size");

  // A new upload is only loaded from an emitting evaluate step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == S_EVAL && emitting && out_free))
    else $error("upload loaded outside an emit step");

  // After the final upload of a run the table holds at most the spilled mark
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && at_last) |=> (cnt_q <= CntOne && state_q == S_IDLE))
    else $error("table not emptied after final upload");

endmodule
